[sv/fplog_pkg.sv]
package fplog_pkg;

    localparam logic [1:0] OP_LOG2  = 2'd0;
    localparam logic [1:0] OP_LN    = 2'd1;
    localparam logic [1:0] OP_LOG10 = 2'd2;

    localparam logic [30:0] LN_SCALE   = 31'h58b90bfc;
    localparam logic [30:0] LG10_SCALE = 31'h268826a1;
    localparam logic [31:0] LOG_MIN    = 32'h8000_0000;

    localparam logic [4:0] FRAC_RESET = 5'd16;
    localparam logic [4:0] FRAC_MIN   = 5'd1;
    localparam logic [4:0] FRAC_MAX   = 5'd30;
    localparam logic [4:0] NORM_LAST  = 5'd4;

    typedef struct packed {
        logic load;
        logic norm;
        logic setup;
        logic square;
        logic scale;
        logic finish;
    } fplog_cmd_t;

    typedef struct packed {
        logic norm_last;
        logic sq_last;
    } fplog_status_t;

endpackage

[sv/fplog_in_if.sv]
interface fplog_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink   (input valid, input op, input operand, output ready);
endinterface

[sv/fplog_out_if.sv]
interface fplog_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] log_value;
    logic               zero_input;

    modport source (output valid, output log_value, output zero_input, input ready);
    modport sink   (input valid, input log_value, input zero_input, output ready);
endinterface

[sv/fplog_dp.sv]
module fplog_dp
    import fplog_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata,
    input  fplog_cmd_t    cmd,
    output fplog_status_t status,
    input  logic [1:0]    in_op,
    input  logic [31:0]   in_operand,
    output logic [31:0]   log_value,
    output logic          zero_input
);

    logic [4:0]         frac_reg;
    logic [4:0]         p_eff;

    logic [1:0]         op_reg,    op_next;
    logic               zero_reg,  zero_next;
    logic [4:0]         p_reg,     p_next;
    logic [31:0]        x_reg,     x_next;
    logic [4:0]         lz_reg,    lz_next;
    logic [4:0]         cnt_reg,   cnt_next;
    logic [30:0]        m_reg,     m_next;
    logic [31:0]        acc_reg,   acc_next;
    logic [29:0]        bit_reg,   bit_next;
    logic signed [63:0] prod_reg,  prod_next;
    logic [31:0]        res_reg,   res_next;
    logic               zout_reg,  zout_next;

    logic [4:0]         lead;
    logic [6:0]         ip;
    logic [61:0]        sq;
    logic [31:0]        t;
    logic [31:0]        two;
    logic [30:0]        coef;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= FRAC_RESET;
        end
        else if (cfg_we)
        begin
            frac_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        p_eff = frac_reg;
        if (frac_reg < FRAC_MIN)
        begin
            p_eff = FRAC_MIN;
        end
        else if (frac_reg > FRAC_MAX)
        begin
            p_eff = FRAC_MAX;
        end
    end

    assign lead = 5'd31 - lz_reg;
    assign ip   = 7'({2'b00, lead}) - 7'({2'b00, p_reg});
    assign sq   = 62'(m_reg) * 62'(m_reg);
    assign t    = 32'(sq >> p_reg);
    assign two  = 32'd2 << p_reg;
    assign coef = (op_reg == OP_LN) ? LN_SCALE : LG10_SCALE;

    assign status.norm_last = (cnt_reg == NORM_LAST);
    assign status.sq_last   = (cnt_reg == (p_reg - 5'd1));

    always_comb
    begin
        op_next   = op_reg;
        zero_next = zero_reg;
        p_next    = p_reg;
        x_next    = x_reg;
        lz_next   = lz_reg;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        zout_next = zout_reg;

        if (cmd.load)
        begin
            op_next   = in_op;
            zero_next = (in_operand == 32'd0);
            p_next    = p_eff;
            x_next    = in_operand;
            lz_next   = 5'd0;
            cnt_next  = 5'd0;
        end

        // leading-zero search, halving the shift each step
        if (cmd.norm)
        begin
            cnt_next = cnt_reg + 5'd1;
            unique case (cnt_reg)
                5'd0:
                begin
                    if (x_reg[31:16] == '0)
                    begin
                        x_next  = x_reg << 16;
                        lz_next = lz_reg + 5'd16;
                    end
                end
                5'd1:
                begin
                    if (x_reg[31:24] == '0)
                    begin
                        x_next  = x_reg << 8;
                        lz_next = lz_reg + 5'd8;
                    end
                end
                5'd2:
                begin
                    if (x_reg[31:28] == '0)
                    begin
                        x_next  = x_reg << 4;
                        lz_next = lz_reg + 5'd4;
                    end
                end
                5'd3:
                begin
                    if (x_reg[31:30] == '0)
                    begin
                        x_next  = x_reg << 2;
                        lz_next = lz_reg + 5'd2;
                    end
                end
                5'd4:
                begin
                    if (!x_reg[31])
                    begin
                        x_next  = x_reg << 1;
                        lz_next = lz_reg + 5'd1;
                    end
                end
                default:
                begin
                    x_next = x_reg;
                end
            endcase
        end

        // mantissa into [1,2), integer part into the accumulator
        if (cmd.setup)
        begin
            m_next   = 31'(x_reg >> (5'd31 - p_reg));
            acc_next = zero_reg ? LOG_MIN : ({{25{ip[6]}}, ip} << p_reg);
            bit_next = 30'd1 << (p_reg - 5'd1);
            cnt_next = 5'd0;
        end

        if (cmd.square)
        begin
            cnt_next = cnt_reg + 5'd1;
            bit_next = bit_reg >> 1;
            if (t >= two)
            begin
                m_next   = 31'(t >> 1);
                acc_next = acc_reg + {2'b00, bit_reg};
            end
            else
            begin
                m_next = 31'(t);
            end
        end

        if (cmd.scale)
        begin
            prod_next = $signed(acc_reg) * $signed({1'b0, coef});
        end

        if (cmd.finish)
        begin
            res_next  = (op_reg == OP_LN || op_reg == OP_LOG10) ? prod_reg[62:31] : acc_reg;
            zout_next = zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        zero_reg <= zero_next;
        p_reg    <= p_next;
        x_reg    <= x_next;
        lz_reg   <= lz_next;
        m_reg    <= m_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        zout_reg <= zout_next;
    end

    assign log_value  = res_reg;
    assign zero_input = zout_reg;

endmodule

[sv/fplog_ctrl.sv]
module fplog_ctrl
    import fplog_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  fplog_status_t status,
    output fplog_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SETUP,
        S_SQUARE,
        S_SCALE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.norm = 1'b1;
                if (status.norm_last)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                if (status.sq_last)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/fixed_point_logarithm.sv]
// Fixed-point log2 / ln / log10 of an unsigned 32-bit value.
// p = effective fraction bits (1..30), the fraction_bits setting clamped to that range.
// One item at a time: a new item is accepted only when idle; the squaring loop runs one step per cycle.
// Leading-zero search, squaring loop, then scaling multiply; output register frees the input.
// Reset: asynchronous active-low; idle, no result pending, fraction_bits = 16.
module fixed_point_logarithm
    import fplog_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    fplog_in_if.sink    in_ch,
    fplog_out_if.source out_ch
);

    fplog_cmd_t    cmd;
    fplog_status_t status;
    logic [31:0]   log_value;

    fplog_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    fplog_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .status     (status),
        .in_op      (in_ch.op),
        .in_operand (in_ch.operand),
        .log_value  (log_value),
        .zero_input (out_ch.zero_input)
    );

    assign out_ch.log_value = $signed(log_value);

endmodule

[tb/sv/fixed_point_logarithm_test.sv]
module fixed_point_logarithm_test;
    import fplog_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASES = 10;
    localparam int RANDOM_PER_PHASE = 163;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] operand;
    } log_request_t;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] operand;
        logic [4:0]  frac;
        logic [31:0] log_value;
        logic        zero_input;
    } log_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_wdata = '0;

    fplog_in_if  in_ch();
    fplog_out_if out_ch();

    fixed_point_logarithm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    log_request_t queued_ops[$];
    log_result_t  expected_logs[$];

    logic [4:0] frac_setting = FRAC_RESET;
    logic       idle_enable = 1'b1;
    logic       src_pause = 1'b0;
    int         hold_requests = 0;
    int         holds_served = 0;
    int         hold_left = 0;
    int         stall_left = 0;
    int         gap_left = 0;
    int         mismatches = 0;
    int         accepted = 0;
    int         zero_seen = 0;
    int         op_seen[4] = '{0, 0, 0, 0};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned effective_frac(logic [4:0] f);
        if (f < FRAC_MIN)
        begin
            return FRAC_MIN;
        end
        if (f > FRAC_MAX)
        begin
            return FRAC_MAX;
        end
        return f;
    endfunction

    // normalize into [1,2) one unit per shift, then one fraction bit per squaring
    function automatic logic [31:0] binary_logarithm(logic [31:0] x, int unsigned p);
        logic [63:0] unit;
        logic [63:0] twice;
        logic [63:0] m;
        logic [31:0] acc;
        logic [31:0] frac_bit;
        if (x == 32'd0)
        begin
            return LOG_MIN;
        end
        unit = 64'd1 << p;
        twice = 64'd2 << p;
        m = {32'd0, x};
        acc = '0;
        frac_bit = 32'd1 << (p - 1);
        while (m < unit)
        begin
            m = m << 1;
            acc = acc - unit[31:0];
        end
        while (m >= twice)
        begin
            m = m >> 1;
            acc = acc + unit[31:0];
        end
        for (int k = 0; k < p; k++)
        begin
            m = (m * m) >> p;
            if (m >= twice)
            begin
                m = m >> 1;
                acc = acc + frac_bit;
            end
            frac_bit = frac_bit >> 1;
        end
        return acc;
    endfunction

    // signed log2 times an unsigned Q0.31 constant, floor by 2^31
    function automatic logic [31:0] scale_q31(logic [31:0] l2, logic [30:0] c);
        logic [63:0] prod;
        prod = {{32{l2[31]}}, l2} * {33'd0, c};
        return prod[62:31];
    endfunction

    function automatic log_result_t predict_log(log_request_t req, logic [4:0] frac);
        log_result_t res;
        logic [31:0] l2;
        l2 = binary_logarithm(req.operand, effective_frac(frac));
        res.op = req.op;
        res.operand = req.operand;
        res.frac = frac;
        res.zero_input = (req.operand == 32'd0);
        case (req.op)
            OP_LN:    res.log_value = scale_q31(l2, LN_SCALE);
            OP_LOG10: res.log_value = scale_q31(l2, LG10_SCALE);
            default:  res.log_value = l2;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] random_op();
        if ($urandom_range(0, 15) == 0)
        begin
            return OP_UNUSED;
        end
        case ($urandom_range(0, 2))
            0:       return OP_LOG2;
            1:       return OP_LN;
            default: return OP_LOG10;
        endcase
    endfunction

    function automatic logic [31:0] random_operand(int unsigned p);
        logic [31:0] one_val;
        one_val = 32'd1 << p;
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1 << $urandom_range(0, 31);
            2:       return one_val - 32'd2 + $urandom_range(0, 4);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            4, 5:    return $urandom;
            default: return $urandom >> $urandom_range(1, 31);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    task automatic push_item(logic [1:0] op, logic [31:0] operand);
        log_request_t req;
        req.op = op;
        req.operand = operand;
        queued_ops.push_back(req);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (queued_ops.size() != 0 || in_ch.valid || expected_logs.size() != 0);
    endtask

    task automatic write_fraction_bits(logic [4:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        frac_setting = v;
    endtask

    // item driver
    always @(posedge clk)
    begin : driver
        log_request_t nxt;
        log_result_t  res;
        logic         go;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                nxt.op = in_ch.op;
                nxt.operand = in_ch.operand;
                res = predict_log(nxt, frac_setting);
                expected_logs.push_back(res);
                accepted++;
                op_seen[in_ch.op]++;
                if (res.zero_input)
                begin
                    zero_seen++;
                end
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                go = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (!src_pause && queued_ops.size() != 0)
                begin
                    if (idle_enable && $urandom_range(0, 7) == 0)
                    begin
                        gap_left = $urandom_range(0, 14);
                    end
                    else
                    begin
                        nxt = queued_ops.pop_front();
                        go = 1'b1;
                    end
                end
                in_ch.valid <= go;
                if (go)
                begin
                    in_ch.op <= nxt.op;
                    in_ch.operand <= nxt.operand;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin : monitor
        log_result_t want;
        logic        go;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_logs.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result log_value=%h zero_input=%b",
                                              out_ch.log_value, out_ch.zero_input));
                end
                else
                begin
                    want = expected_logs.pop_front();
                    if (out_ch.log_value !== want.log_value)
                    begin
                        report_mismatch($sformatf(
                            "op=%0d operand=%h frac=%0d log_value got %h want %h",
                            want.op, want.operand, want.frac, out_ch.log_value,
                            want.log_value));
                    end
                    if (out_ch.zero_input !== want.zero_input)
                    begin
                        report_mismatch($sformatf(
                            "op=%0d operand=%h frac=%0d zero_input got %b want %b",
                            want.op, want.operand, want.frac, out_ch.zero_input,
                            want.zero_input));
                    end
                end
            end
            go = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 14);
            end
            else
            begin
                go = 1'b1;
            end
            out_ch.ready <= go;
        end
    end

    initial
    begin : stimulus
        logic [4:0]  phase_frac[PHASES];
        int unsigned p;
        int          mark;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOG2;
        in_ch.operand = '0;
        out_ch.ready = 1'b0;
        phase_frac = '{5'd1, 5'd30, 5'd0, 5'd31, 5'd16, 5'd8, 5'd23, 5'd0, 5'd0, 5'd0};
        for (int i = PHASES - 3; i < PHASES; i++)
        begin
            phase_frac[i] = $urandom_range(0, 31);
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting: zero and the maximum under every op, exact powers under log2, ln and log10
        for (int i = 0; i < 4; i++)
        begin
            push_item(2'(i), 32'd0);
            push_item(2'(i), 32'hFFFF_FFFF);
        end
        push_item(OP_LOG2, 32'h0001_0000);
        push_item(OP_LN, 32'h0001_0000);
        push_item(OP_LOG10, 32'h0001_0000);
        push_item(OP_LOG2, 32'd1);
        push_item(OP_LN, 32'd1);
        push_item(OP_LOG10, 32'd1);
        push_item(OP_LOG2, 32'h8000_0000);
        push_item(OP_LOG2, 32'h0001_8000);
        push_item(OP_LOG2, 32'h0000_FFFF);
        push_item(OP_LOG2, 32'h0001_0001);
        push_item(OP_LOG2, 32'h0002_0000);
        push_item(OP_LN, 32'h1234_5678);
        push_item(OP_LOG10, 32'h000A_0000);
        push_item(OP_UNUSED, 32'h0003_0000);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 4 || ph == PHASES - 1)
            begin
                idle_enable = 1'b0;
            end
            else
            begin
                idle_enable = 1'b1;
            end
            write_fraction_bits(phase_frac[ph]);
            p = effective_frac(phase_frac[ph]);
            push_item(random_op(), 32'd0);
            push_item(random_op(), 32'd1);
            push_item(random_op(), 32'hFFFF_FFFF);
            push_item(random_op(), 32'd1 << p);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                push_item(random_op(), random_operand(p));
            end
            if (ph == 1)
            begin
                // receiver blocks while items keep coming, input must back up
                hold_requests++;
            end
            if (ph == 2)
            begin
                mark = accepted;
                do
                begin
                    @(negedge clk);
                end
                while (accepted < mark + 40);
                src_pause = 1'b1;
                do
                begin
                    @(negedge clk);
                end
                while (in_ch.valid || expected_logs.size() != 0);
                src_pause = 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d items over %0d fraction_bits settings (incl. 0 and 31)",
                 accepted, PHASES + 1);
        $display("log2 %0d, ln %0d, log10 %0d, unused op %0d, zero operands %0d",
                 op_seen[OP_LOG2], op_seen[OP_LN], op_seen[OP_LOG10], op_seen[OP_UNUSED],
                 zero_seen);
        if (mismatches == 0 && expected_logs.size() == 0)
        begin
            $display("fixed_point_logarithm_test: PASS");
        end
        else
        begin
            $display("fixed_point_logarithm_test: FAIL");
        end
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("timeout with %0d results outstanding", expected_logs.size());
        $display("fixed_point_logarithm_test: FAIL");
        $finish;
    end

endmodule

[fixed_point_logarithm.f]
sv/fplog_pkg.sv
sv/fplog_in_if.sv
sv/fplog_out_if.sv
sv/fplog_dp.sv
sv/fplog_ctrl.sv
sv/fixed_point_logarithm.sv
tb/sv/fixed_point_logarithm_test.sv
